/* rtl/isort_pkg.sv */
package isort_pkg;

    typedef struct packed {
        logic signed [31:0] sample_value;
        logic               final_item;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               end_of_set;
        logic               overflowed;
    } out_item_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic latch_in;    // capture the input transfer
        logic set_drop;    // store full, mark the set as overflowed
        logic ins_start;   // insertion slot starts at the fill count
        logic rd_lower;    // read the entry just below the slot
        logic rd_next;     // read two below the slot, ahead of a shift
        logic wr_shift;    // move the read entry up into the slot
        logic wr_value;    // write the held value into the slot
        logic emit_start;  // emit pointer to the bottom entry
        logic emit_rd;     // read the entry at the emit pointer
        logic emit_load;   // load the result register
        logic clear_set;   // empty the store for the next set
    } cmd_t;

    typedef struct packed {
        logic full;        // store holds the maximum number of entries
        logic slot_zero;
        logic slot_one;
        logic gt;          // entry read is larger than the held value
        logic last_flag;   // held item ends the set
        logic emit_last;   // emit pointer is at the top entry
        logic out_free;    // result register empty or emptying now
    } status_t;

endpackage

/* rtl/isort_dpath.sv */
module isort_dpath #(
    parameter int DEPTH = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  isort_pkg::in_item_t  s_data,
    input  isort_pkg::cmd_t      cmd,
    output isort_pkg::status_t   sts,
    output logic                 m_valid,
    input  logic                 m_ready,
    output isort_pkg::out_item_t m_data
);
    import isort_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic signed [31:0] mem [DEPTH];

    logic signed [31:0] value_reg;
    logic               last_reg;
    logic signed [31:0] rd_data_reg;
    logic [CW-1:0]      fill_reg, fill_next;
    logic [CW-1:0]      slot_reg, slot_next;
    logic               drop_reg, drop_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_reg;

    logic [CW-1:0]      rd_ptr;
    logic               rd_en;
    logic               wr_en;

    always_comb begin
        rd_ptr = slot_reg;
        if (cmd.rd_lower) begin
            rd_ptr = slot_reg - CW'(1);
        end else if (cmd.rd_next) begin
            rd_ptr = slot_reg - CW'(2);
        end
    end

    assign rd_en = cmd.rd_lower | cmd.rd_next | cmd.emit_rd;
    assign wr_en = cmd.wr_shift | cmd.wr_value;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[slot_reg[AW-1:0]] <= cmd.wr_shift ? rd_data_reg : value_reg;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_ptr[AW-1:0]];
        end
        if (cmd.latch_in) begin
            value_reg <= s_data.sample_value;
            last_reg  <= s_data.final_item;
        end
        if (cmd.emit_load) begin
            out_reg.sorted_value <= rd_data_reg;
            out_reg.end_of_set   <= sts.emit_last;
            out_reg.overflowed   <= drop_reg;
        end
    end

    always_comb begin
        fill_next = fill_reg;
        if (cmd.clear_set) begin
            fill_next = '0;
        end else if (cmd.wr_value) begin
            fill_next = fill_reg + CW'(1);
        end

        drop_next = drop_reg;
        if (cmd.clear_set) begin
            drop_next = 1'b0;
        end else if (cmd.set_drop) begin
            drop_next = 1'b1;
        end

        slot_next = slot_reg;
        if (cmd.ins_start) begin
            slot_next = fill_reg;
        end else if (cmd.emit_start) begin
            slot_next = '0;
        end else if (cmd.wr_shift) begin
            slot_next = slot_reg - CW'(1);
        end else if (cmd.emit_load) begin
            slot_next = slot_reg + CW'(1);
        end

        out_valid_next = out_valid_reg;
        if (cmd.emit_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            drop_reg      <= 1'b0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            fill_reg      <= fill_next;
            drop_reg      <= drop_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign sts.full      = (fill_reg == CW'(DEPTH));
    assign sts.slot_zero = (slot_reg == '0);
    assign sts.slot_one  = (slot_reg == CW'(1));
    assign sts.gt        = (rd_data_reg > value_reg);
    assign sts.last_flag = last_reg;
    assign sts.emit_last = ((slot_reg + CW'(1)) == fill_reg);
    assign sts.out_free  = !out_valid_reg || m_ready;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CW'(DEPTH))
        else $error("fill count beyond capacity");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_load |-> !out_valid_reg)
        else $error("result register loaded while a result is pending");

    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (slot_reg <= fill_reg) && !sts.full)
        else $error("store write outside the filled range");

    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear_set |=> (fill_reg == '0) && !drop_reg)
        else $error("set not emptied after emission");

endmodule

/* rtl/isort_ctrl.sv */
module isort_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               in_final,
    input  isort_pkg::status_t sts,
    output isort_pkg::cmd_t    cmd
);
    import isort_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_RD   = 5'b00010,
        ST_CMP  = 5'b00100,
        ST_ERD  = 5'b01000,
        ST_ELD  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch_in = 1'b1;
                    if (sts.full) begin
                        // value dropped, a final item still flushes the set
                        cmd.set_drop = 1'b1;
                        if (in_final) begin
                            cmd.emit_start = 1'b1;
                            state_next     = ST_ERD;
                        end
                    end else begin
                        cmd.ins_start = 1'b1;
                        state_next    = ST_RD;
                    end
                end
            end
            ST_RD: begin
                if (sts.slot_zero) begin
                    cmd.wr_value = 1'b1;
                    if (sts.last_flag) begin
                        cmd.emit_start = 1'b1;
                        state_next     = ST_ERD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    cmd.rd_lower = 1'b1;
                    state_next   = ST_CMP;
                end
            end
            ST_CMP: begin
                if (sts.gt) begin
                    cmd.wr_shift = 1'b1;
                    if (sts.slot_one) begin
                        // bottom reached, value goes into slot zero
                        state_next = ST_RD;
                    end else begin
                        cmd.rd_next = 1'b1;
                    end
                end else begin
                    cmd.wr_value = 1'b1;
                    if (sts.last_flag) begin
                        cmd.emit_start = 1'b1;
                        state_next     = ST_ERD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ERD: begin
                if (sts.out_free) begin
                    cmd.emit_rd = 1'b1;
                    state_next  = ST_ELD;
                end
            end
            ST_ELD: begin
                cmd.emit_load = 1'b1;
                if (sts.emit_last) begin
                    cmd.clear_set = 1'b1;
                    state_next    = ST_IDLE;
                end else begin
                    state_next = ST_ERD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_accept_idle_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> (state_reg == ST_IDLE))
        else $error("input transfer outside idle");

    a_emit_pairs: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_rd |=> cmd.emit_load)
        else $error("emit read not followed by load");

    a_insert_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wr_value && !sts.last_flag) |=> (state_reg == ST_IDLE))
        else $error("controller not idle after insertion");

endmodule

/* rtl/insertion_sorter_core.sv */
// Insertion sorter for signed 32-bit values. Each input transfer carries one
// value, which is inserted at once into a sorted store of DEPTH entries held in
// a single-port-write, single-port-read memory with a registered read. The
// insertion walks down from the top of the filled range, moving one larger
// entry up per clock, and the next input is taken only once the value is
// stored or dropped; only one value is in work at a time. A transfer marked
// final_item is inserted first, then the whole set is emitted in ascending
// order, each result read from memory once the result register is free and
// then loaded into the result register, with end_of_set on the last result.
// Values that arrive while the store is full are dropped and every result
// of that set carries overflowed. The next set may start once the last
// result is loaded into the result register, even while it still waits to
// be taken.
module insertion_sorter_core #(
    parameter int DEPTH = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  isort_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output isort_pkg::out_item_t m_data
);
    import isort_pkg::*;

    cmd_t    cmd;
    status_t sts;

    isort_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .in_final (s_data.final_item),
        .sts      (sts),
        .cmd      (cmd)
    );

    isort_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

/* test/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import isort_pkg::*;

    localparam int DEPTH       = 64;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_WAIT  = 200;
    localparam int HOLD_LEN    = 400;
    localparam int TARGET_ITEMS = 348;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PATTERN
    } rx_mode_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    // predictor state
    logic signed [31:0] shadow_store [DEPTH];
    int                 shadow_fill = 0;
    logic               shadow_drop = 1'b0;

    in_item_t  samples_to_send [$];
    out_item_t sorted_results_due [$];
    out_item_t want_item;

    int        mismatch_count = 0;
    int        cycle_count = 0;
    int        burst_left = 0;
    int        gap_left = 0;
    int        rx_cycle = 0;
    int        hold_left = 0;

    insertion_sorter_core #(
        .DEPTH(DEPTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40) begin
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        end
    endtask

    // insert one accepted sample; a final sample releases the whole set in order
    task automatic insert_and_collect(input in_item_t item);
        int        slot;
        out_item_t res;
        if (shadow_fill >= DEPTH) begin
            shadow_drop = 1'b1;
        end else begin
            slot = shadow_fill;
            while (slot > 0 && shadow_store[slot-1] > item.sample_value) begin
                shadow_store[slot] = shadow_store[slot-1];
                slot--;
            end
            shadow_store[slot] = item.sample_value;
            shadow_fill++;
        end
        if (item.final_item) begin
            for (int k = 0; k < shadow_fill; k++) begin
                res.sorted_value = shadow_store[k];
                res.end_of_set   = (k == shadow_fill - 1);
                res.overflowed   = shadow_drop;
                sorted_results_due.push_back(res);
            end
            shadow_fill = 0;
            shadow_drop = 1'b0;
        end
    endtask

    task automatic queue_sample(input logic signed [31:0] value, input logic last);
        in_item_t item;
        item.sample_value = value;
        item.final_item   = last;
        samples_to_send.push_back(item);
    endtask

    function automatic logic signed [31:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return int'($urandom_range(0, 7)) - 4;  // dense range, many duplicates
            default: return $urandom;
        endcase
    endfunction

    // sender: bursts with random gaps, predicts each transfer as it is accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                insert_and_collect(s_data);
            end
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (samples_to_send.size() > 0) begin
                s_valid <= 1'b1;
                s_data  <= samples_to_send.pop_front();
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: changing stall patterns plus a long hold-off now and then
    always @(posedge aclk) begin
        rx_cycle++;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (rx_cycle % 2500 == 1200) begin
            hold_left = HOLD_LEN;
            m_ready <= 1'b0;
        end else begin
            case (rx_mode_t'(rx_cycle[9:8]))
                RX_OPEN:    m_ready <= 1'b1;
                RX_COIN:    m_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE:  m_ready <= ($urandom_range(0, 3) == 0);
                RX_PATTERN: m_ready <= rx_cycle[2] ^ rx_cycle[0];
                default:    m_ready <= 1'b1;
            endcase
        end
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (sorted_results_due.size() == 0) begin
                report_mismatch($sformatf("result %0d with nothing due", m_data.sorted_value));
            end else begin
                want_item = sorted_results_due.pop_front();
                if (m_data.sorted_value !== want_item.sorted_value) begin
                    report_mismatch($sformatf("sorted_value %0d, want %0d",
                                              m_data.sorted_value, want_item.sorted_value));
                end
                if (m_data.end_of_set !== want_item.end_of_set) begin
                    report_mismatch($sformatf("end_of_set %b, want %b",
                                              m_data.end_of_set, want_item.end_of_set));
                end
                if (m_data.overflowed !== want_item.overflowed) begin
                    report_mismatch($sformatf("overflowed %b, want %b",
                                              m_data.overflowed, want_item.overflowed));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int total;
        int set_idx;
        int set_len;

        // directed sets: extremes, duplicates, reverse order, one-value sets
        queue_sample(32'sd0, 1'b1);
        queue_sample(VAL_MAX, 1'b0);
        queue_sample(VAL_MIN, 1'b0);
        queue_sample(-32'sd1, 1'b0);
        queue_sample(32'sd0, 1'b0);
        queue_sample(32'sd1, 1'b0);
        queue_sample(-32'sd1, 1'b1);
        queue_sample(32'sd40, 1'b0);
        queue_sample(32'sd30, 1'b0);
        queue_sample(32'sd20, 1'b0);
        queue_sample(32'sd10, 1'b0);
        queue_sample(32'sd0, 1'b1);
        for (int k = 0; k < 4; k++) begin
            queue_sample(32'sd7, k == 3);
        end
        for (int k = 1; k <= 4; k++) begin
            queue_sample(k, k == 4);
        end
        queue_sample(VAL_MIN, 1'b1);
        queue_sample(VAL_MAX, 1'b1);

        // random sets, mostly short; a store filled exactly, and two that overflow
        total = 0;
        set_idx = 0;
        while (total < TARGET_ITEMS) begin
            case (set_idx)
                2:       set_len = DEPTH;
                8:       set_len = DEPTH + 1;
                15:      set_len = DEPTH + 6;
                default: set_len = ($urandom_range(0, 15) == 0) ? $urandom_range(16, 40)
                                                                : $urandom_range(1, 12);
            endcase
            for (int k = 0; k < set_len; k++) begin
                queue_sample(pick_value(), k == set_len - 1);
            end
            total += set_len;
            set_idx++;
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        do begin
            @(negedge aclk);
        end while (samples_to_send.size() > 0 || s_valid || sorted_results_due.size() > 0);
        repeat (DRAIN_WAIT) @(negedge aclk);

        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/isort_pkg.sv
rtl/isort_dpath.sv
rtl/isort_ctrl.sv
rtl/insertion_sorter_core.sv
test/tb_top.sv
